[design/star_delta_starter_relay_sequencer_core_assert.svh]
// assertion macros shared by the star-delta sequencer files
// each macro expands to one labelled concurrent assertion on clk, disabled in rst
`ifndef STAR_DELTA_STARTER_RELAY_SEQUENCER_CORE_ASSERT_SVH
`define STAR_DELTA_STARTER_RELAY_SEQUENCER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SDSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SDSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sdsr_pkg.sv]
// ----------------------------------------------------------------------------
// sdsr_pkg
// Shared constants, codes and types of the star-delta relay sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdsr_pkg;

  // field widths
  localparam int DELAY_W    = 6;
  localparam int CSTATE_W   = 2;
  localparam int STAGE_W    = 14;
  localparam int OFF_W      = 8;
  localparam int NUM_RELAYS = 4;

  // timing constants
  localparam int TICK_MS_DEF = 5;
  localparam logic [STAGE_W-1:0] STAGE_TIMER_MAX = 14'd16383;
  localparam logic [OFF_W-1:0]   OFF_TIMER_MAX   = 8'd255;
  localparam logic [OFF_W-1:0]   ON_DELAY_TICKS  = 8'd20;
  localparam int GAP_MS   = 100;
  localparam int MS_PER_S = 1000;

  // relay bit positions
  localparam int R_UP    = 0;
  localparam int R_DOWN  = 1;
  localparam int R_STAR  = 2;
  localparam int R_DELTA = 3;

  // controller state codes
  localparam logic [CSTATE_W-1:0] CSTATE_READY = 2'd1;
  localparam logic [CSTATE_W-1:0] CSTATE_RUN   = 2'd2;

  // motor winding command codes
  localparam logic [1:0] MOTOR_NONE  = 2'b00;
  localparam logic [1:0] MOTOR_STAR  = 2'b01;
  localparam logic [1:0] MOTOR_DELTA = 2'b10;

  // configuration port
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_DELAY_ADDR = 2'd0;

  // sequencer result handed to the relay lanes and the result register
  typedef struct packed {
    logic [NUM_RELAYS-1:0] request;
    logic [1:0]            motor_cmd;
    logic                  clear_check;
  } seq_out_t;

endpackage

[design/star_delta_starter_relay_sequencer_core.sv]
// ----------------------------------------------------------------------------
// star_delta_starter_relay_sequencer_core
// Star-delta motor starter relay sequencer, one word per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one tick word: controller state,
//   direction order, up test order and starting-check flag. Output channel
//   (out_valid/out_ready) returns one result word per tick: the four relay
//   drives, the two winding command bits and the check-clear flag.
//   The star time in seconds is written over the APB port at address 0;
//   write it only while no tick word is in flight.
//   A result word is presented the cycle after its tick word is accepted.
//   One tick word is taken per cycle while the receiver keeps up; all work
//   is done in one pass of logic between the input and the result register.
//   A stalled receiver holds the result register; a new tick word is still
//   taken in the cycle the waiting result leaves, so in_ready only drops
//   while a result waits and out_ready is low.
//   Reset (rst, synchronous) clears the star time, the stage sequence, all
//   relay timers and drives, and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module star_delta_starter_relay_sequencer_core
  import sdsr_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // tick words in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CSTATE_W-1:0]   controller_state,
  input  logic                  direction_up,
  input  logic                  activate_up_order,
  input  logic                  starting_check,
  // result words out
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  relay_up_on,
  output logic                  relay_down_on,
  output logic                  relay_star_on,
  output logic                  relay_delta_on,
  output logic                  motor_star_cmd,
  output logic                  motor_delta_cmd,
  output logic                  clear_starting_check
);

`include "star_delta_starter_relay_sequencer_core_assert.svh"

  logic [DELAY_W-1:0]    delay_s;
  logic                  accept;
  seq_out_t              seq_out;
  logic [NUM_RELAYS-1:0] drive_next;

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  sdsr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delay_s (delay_s)
  );

  sdsr_seq #(
    .TICK_MS (TICK_MS)
  ) u_seq (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .delay_s           (delay_s),
    .controller_state  (controller_state),
    .direction_up      (direction_up),
    .activate_up_order (activate_up_order),
    .starting_check    (starting_check),
    .seq_out           (seq_out)
  );

  sdsr_relay u_relay (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .request    (seq_out.request),
    .drive_next (drive_next)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (accept) begin
      relay_up_on          <= drive_next[R_UP];
      relay_down_on        <= drive_next[R_DOWN];
      relay_star_on        <= drive_next[R_STAR];
      relay_delta_on       <= drive_next[R_DELTA];
      motor_star_cmd       <= seq_out.motor_cmd[0];
      motor_delta_cmd      <= seq_out.motor_cmd[1];
      clear_starting_check <= seq_out.clear_check;
    end
  end

  // checks
  `SDSR_ASSERT_NOW(a_star_delta_excl, out_valid, !(relay_star_on && relay_delta_on),
    "star and delta relays driven together")
  `SDSR_ASSERT_NOW(a_motor_cmd_excl, out_valid, !(motor_star_cmd && motor_delta_cmd),
    "motor command is both star and delta")
  `SDSR_ASSERT_NEXT(a_accept_gives_word, in_valid && in_ready, out_valid,
    "accepted tick word produced no result word")

endmodule

[design/sdsr_cfg.sv]
// ----------------------------------------------------------------------------
// sdsr_cfg
// APB register file holding the star time in seconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsr_cfg
  import sdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DELAY_W-1:0]    delay_s
);

  logic wr_en;

  // no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_DELAY_ADDR);

  // delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_s <= '0;
    end else if (wr_en) begin
      delay_s <= pwdata[DELAY_W-1:0];
    end
  end

  // read back
  assign prdata = (paddr == REG_DELAY_ADDR) ? APB_DATA_W'(delay_s) : '0;

endmodule

[design/sdsr_seq.sv]
// ----------------------------------------------------------------------------
// sdsr_seq
// Star-delta stage sequencer: stage timer, motor command and relay requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsr_seq
  import sdsr_pkg::*;
#(
  parameter int TICK_MS = TICK_MS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [DELAY_W-1:0]  delay_s,
  input  logic [CSTATE_W-1:0] controller_state,
  input  logic                direction_up,
  input  logic                activate_up_order,
  input  logic                starting_check,
  output seq_out_t            seq_out
);

  localparam int PROD_W = STAGE_W + $clog2(TICK_MS + 1);
  localparam int THR_W  = DELAY_W + $clog2(MS_PER_S + 1);
  localparam int CMP_W  = (PROD_W > THR_W) ? PROD_W : THR_W;

  typedef enum logic [1:0] {
    STAGE_STAR,
    STAGE_GAP,
    STAGE_DONE
  } stage_t;

  stage_t                switch_stage, switch_stage_next;
  logic                  switch_done, switch_done_next;
  logic [STAGE_W-1:0]    stage_timer, stage_timer_next;
  logic [NUM_RELAYS-1:0] relay_request, relay_request_next;

  logic [STAGE_W-1:0]    timer_inc;
  logic [CMP_W-1:0]      elapsed_ms;
  logic [CMP_W-1:0]      star_limit_ms;
  logic [NUM_RELAYS-1:0] dir_mask;
  logic [1:0]            motor_cmd;
  logic                  clear_check;

  // saturating timer step and elapsed time in ms
  assign timer_inc     = (stage_timer < STAGE_TIMER_MAX) ? stage_timer + STAGE_W'(1)
                                                         : stage_timer;
  assign elapsed_ms    = CMP_W'(timer_inc) * CMP_W'(TICK_MS);
  assign star_limit_ms = CMP_W'(delay_s) * CMP_W'(MS_PER_S);

  // direction relay for this tick
  always_comb begin
    dir_mask = '0;
    if (direction_up) begin
      dir_mask[R_UP] = 1'b1;
    end else begin
      dir_mask[R_DOWN] = 1'b1;
    end
  end

  // winding command from the stage reached so far
  always_comb begin
    if ((delay_s == '0) || switch_done) begin
      motor_cmd = MOTOR_DELTA;
    end else if (switch_stage == STAGE_GAP) begin
      motor_cmd = MOTOR_NONE;
    end else begin
      motor_cmd = MOTOR_STAR;
    end
  end

  // request and stage update
  always_comb begin
    switch_stage_next  = switch_stage;
    switch_done_next   = switch_done;
    stage_timer_next   = stage_timer;
    relay_request_next = relay_request;
    clear_check        = 1'b0;
    if (starting_check && (controller_state == CSTATE_READY)) begin
      // starting check: only the up relay follows the test order
      relay_request_next[R_UP] = activate_up_order;
      clear_check              = !activate_up_order;
    end else if (controller_state != CSTATE_RUN) begin
      relay_request_next = '0;
      switch_done_next   = 1'b0;
      switch_stage_next  = STAGE_STAR;
      stage_timer_next   = '0;
    end else begin
      relay_request_next = '0;
      if (switch_stage == STAGE_GAP) begin
        relay_request_next = dir_mask;
      end
      if (motor_cmd == MOTOR_DELTA) begin
        relay_request_next[R_DELTA] = 1'b1;
        relay_request_next          = relay_request_next | dir_mask;
      end else if (motor_cmd == MOTOR_STAR) begin
        relay_request_next[R_STAR] = 1'b1;
        relay_request_next         = relay_request_next | dir_mask;
      end
      if ((delay_s != '0) && (switch_stage == STAGE_STAR)) begin
        stage_timer_next = timer_inc;
        if (elapsed_ms > star_limit_ms) begin
          relay_request_next[R_STAR]  = 1'b0;
          relay_request_next[R_DELTA] = 1'b0;
          switch_stage_next           = STAGE_GAP;
          stage_timer_next            = '0;
        end
      end else if (switch_stage == STAGE_GAP) begin
        stage_timer_next = timer_inc;
        if (elapsed_ms > CMP_W'(GAP_MS)) begin
          switch_stage_next = STAGE_DONE;
          switch_done_next  = 1'b1;
          stage_timer_next  = '0;
        end
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_stage  <= STAGE_STAR;
      switch_done   <= 1'b0;
      stage_timer   <= '0;
      relay_request <= '0;
    end else if (accept) begin
      switch_stage  <= switch_stage_next;
      switch_done   <= switch_done_next;
      stage_timer   <= stage_timer_next;
      relay_request <= relay_request_next;
    end
  end

  assign seq_out.request     = relay_request_next;
  assign seq_out.motor_cmd   = motor_cmd;
  assign seq_out.clear_check = clear_check;

endmodule

[design/sdsr_relay.sv]
// ----------------------------------------------------------------------------
// sdsr_relay
// Four relay lanes with switch-on delay after an off period; off is immediate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdsr_relay
  import sdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [NUM_RELAYS-1:0] request,
  output logic [NUM_RELAYS-1:0] drive_next
);

  logic [OFF_W-1:0]      off_timer [NUM_RELAYS];
  logic [OFF_W-1:0]      off_timer_next [NUM_RELAYS];
  logic [NUM_RELAYS-1:0] was_requested, was_requested_next;
  logic [NUM_RELAYS-1:0] drive;

  // per-lane on-delay logic
  always_comb begin
    logic [OFF_W-1:0] step;
    for (int i = 0; i < NUM_RELAYS; i++) begin
      step = (off_timer[i] < OFF_TIMER_MAX) ? off_timer[i] + OFF_W'(1) : off_timer[i];
      if (!request[i]) begin
        drive_next[i]         = 1'b0;
        off_timer_next[i]     = was_requested[i] ? '0 : step;
        was_requested_next[i] = 1'b0;
      end else begin
        drive_next[i]         = drive[i] || (step > ON_DELAY_TICKS);
        off_timer_next[i]     = step;
        was_requested_next[i] = 1'b1;
      end
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      drive         <= '0;
      was_requested <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        off_timer[i] <= '0;
      end
    end else if (accept) begin
      drive         <= drive_next;
      was_requested <= was_requested_next;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        off_timer[i] <= off_timer_next[i];
      end
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the star-delta starter relay sequencer. Tick words
// go in over valid/ready with random gaps; an in-bench model of the relay
// sequence predicts every result word and a scoreboard compares them in order.
// The star time is changed over APB between phases, read back each time.
// ----------------------------------------------------------------------------

module testbench;
  import sdsr_pkg::*;

  // controller state codes the package leaves unnamed
  localparam logic [CSTATE_W-1:0] CSTATE_OTHER = 2'd0;
  localparam logic [CSTATE_W-1:0] CSTATE_SPARE = 2'd3;

  // star-delta stages
  localparam logic [1:0] STAGE_STAR     = 2'd0;
  localparam logic [1:0] STAGE_GAP      = 2'd1;
  localparam logic [1:0] STAGE_SWITCHED = 2'd2;

  localparam int STALL_LIMIT   = 1000;
  localparam int LONG_HOLD     = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic [CSTATE_W-1:0] cstate;
    logic                up;
    logic                test_up;
    logic                check;
  } tick_t;

  typedef struct packed {
    logic [NUM_RELAYS-1:0] drive;
    logic [1:0]            winding;
    logic                  clear;
  } relay_word_t;

  // models the relay sequence and holds the result words still to come
  class relay_sequence_tracker;
    logic [DELAY_W-1:0]    star_secs;
    logic [1:0]            stage;
    logic                  switched;
    logic [STAGE_W-1:0]    stage_ticks;
    logic [OFF_W-1:0]      off_ticks [NUM_RELAYS];
    logic [NUM_RELAYS-1:0] was_requested;
    logic [NUM_RELAYS-1:0] request;
    logic [NUM_RELAYS-1:0] drive;
    logic [1:0]            winding;
    relay_word_t           expected_words [$];
    int errors;
    int checked;
    int star_words;
    int delta_words;
    int gap_words;
    int clear_words;

    function new();
      star_secs     = '0;
      stage         = STAGE_STAR;
      switched      = 1'b0;
      stage_ticks   = '0;
      was_requested = '0;
      request       = '0;
      drive         = '0;
      winding       = MOTOR_NONE;
      foreach (off_ticks[i]) off_ticks[i] = '0;
      errors      = 0;
      checked     = 0;
      star_words  = 0;
      delta_words = 0;
      gap_words   = 0;
      clear_words = 0;
    endfunction

    function void bump_stage_timer();
      if (stage_ticks < STAGE_TIMER_MAX) stage_ticks++;
    endfunction

    // advance one tick and queue the word it produces
    function void note_tick(tick_t t);
      relay_word_t           w;
      logic [NUM_RELAYS-1:0] dir;
      logic                  clear;
      clear = 1'b0;
      foreach (off_ticks[i]) begin
        if (off_ticks[i] < OFF_TIMER_MAX) off_ticks[i]++;
      end

      // winding command from the stage reached so far
      if (star_secs == 0 || switched) winding = MOTOR_DELTA;
      else if (stage == STAGE_GAP) winding = MOTOR_NONE;
      else winding = MOTOR_STAR;

      if (t.check && t.cstate == CSTATE_READY) begin
        // starting check: only the up contactor follows the test order
        if (t.test_up) begin
          request[R_UP] = 1'b1;
        end else begin
          request[R_UP] = 1'b0;
          clear = 1'b1;
        end
      end else if (t.cstate != CSTATE_RUN) begin
        request     = '0;
        switched    = 1'b0;
        stage       = STAGE_STAR;
        stage_ticks = '0;
      end else begin
        dir = '0;
        if (t.up) dir[R_UP] = 1'b1;
        else dir[R_DOWN] = 1'b1;
        request = '0;
        if (stage == STAGE_GAP) request |= dir;
        if (winding == MOTOR_DELTA) begin
          request |= dir;
          request[R_DELTA] = 1'b1;
        end else if (winding == MOTOR_STAR) begin
          request |= dir;
          request[R_STAR] = 1'b1;
        end
        // star time, then the open gap before delta
        if (star_secs != 0 && stage == STAGE_STAR) begin
          bump_stage_timer();
          if (int'(stage_ticks) * TICK_MS_DEF > int'(star_secs) * MS_PER_S) begin
            request[R_STAR]  = 1'b0;
            request[R_DELTA] = 1'b0;
            stage            = STAGE_GAP;
            stage_ticks      = '0;
          end
        end else if (stage == STAGE_GAP) begin
          bump_stage_timer();
          if (int'(stage_ticks) * TICK_MS_DEF > GAP_MS) begin
            stage       = STAGE_SWITCHED;
            switched    = 1'b1;
            stage_ticks = '0;
          end
        end
      end

      // drives switch on only after a long enough off time
      for (int i = 0; i < NUM_RELAYS; i++) begin
        if (!request[i]) begin
          drive[i] = 1'b0;
          if (was_requested[i]) off_ticks[i] = '0;
          was_requested[i] = 1'b0;
        end else begin
          was_requested[i] = 1'b1;
          if (off_ticks[i] > ON_DELAY_TICKS) drive[i] = 1'b1;
        end
      end

      w.drive   = drive;
      w.winding = winding;
      w.clear   = clear;
      expected_words.push_back(w);
    endfunction

    function void compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s expected %0b, got %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [NUM_RELAYS-1:0] got_drive, logic [1:0] got_winding,
                             logic got_clear);
      relay_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word arrived with no tick waiting for it", $time);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      checked++;
      compare_bit("relay_up_on", want.drive[R_UP], got_drive[R_UP]);
      compare_bit("relay_down_on", want.drive[R_DOWN], got_drive[R_DOWN]);
      compare_bit("relay_star_on", want.drive[R_STAR], got_drive[R_STAR]);
      compare_bit("relay_delta_on", want.drive[R_DELTA], got_drive[R_DELTA]);
      compare_bit("motor_star_cmd", want.winding[0], got_winding[0]);
      compare_bit("motor_delta_cmd", want.winding[1], got_winding[1]);
      compare_bit("clear_starting_check", want.clear, got_clear);
      if (want.drive[R_STAR]) star_words++;
      if (want.drive[R_DELTA]) delta_words++;
      if (want.winding == MOTOR_NONE) gap_words++;
      if (want.clear) clear_words++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CSTATE_W-1:0]   controller_state = '0;
  logic                  direction_up = 1'b0;
  logic                  activate_up_order = 1'b0;
  logic                  starting_check = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  relay_up_on;
  logic                  relay_down_on;
  logic                  relay_star_on;
  logic                  relay_delta_on;
  logic                  motor_star_cmd;
  logic                  motor_delta_cmd;
  logic                  clear_starting_check;

  relay_sequence_tracker sb;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int ticks_sent = 0;
  int idle_cycles = 0;
  int star_delays [NUM_PHASES] = '{1, 0, 63, 2, 60, 1};
  int phase_lengths [NUM_PHASES] = '{300, 200, 150, 500, 150, 200};

  star_delta_starter_relay_sequencer_core dut (.*);

  always #1 clk = ~clk;

  // offer one tick word, with an occasional gap before it
  task automatic offer(input logic [CSTATE_W-1:0] cs, input logic up, input logic tu,
                       input logic chk);
    tick_t t;
    t.cstate  = cs;
    t.up      = up;
    t.test_up = tu;
    t.check   = chk;
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    controller_state  <= cs;
    direction_up      <= up;
    activate_up_order <= tu;
    starting_check    <= chk;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
    ticks_sent++;
  endtask

  // stop offering and let every result word come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the star time, then read it back
  task automatic write_delay(input logic [DELAY_W-1:0] secs);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DELAY_ADDR;
    pwdata  <= ($urandom() & ~32'h3F) | 32'(secs);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.star_secs = secs;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[DELAY_W-1:0] !== secs) begin
      $display("%0t: star time read back expected %0d, got %0d", $time, secs,
               prdata[DELAY_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly run stretches, which may reach delta for star times up to 2 s, plus check tests and noise
  task automatic run_phase(input int count, input int secs);
    int   sent;
    int   len;
    int   kind;
    logic up;
    logic tu;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        if (secs == 0) len = $urandom_range(10, 80);
        else if (secs <= 2) len = secs * 200 - 20 + $urandom_range(0, 100);
        else len = $urandom_range(30, 150);
        up = 1'($urandom_range(0, 1));
        for (int j = 0; j < len && sent < count; j++) begin
          if ($urandom_range(0, 99) == 0) up = ~up;
          offer(CSTATE_RUN, up, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end else if (kind < 80) begin
        len = $urandom_range(3, 30);
        tu  = 1'($urandom_range(0, 1));
        for (int j = 0; j < len && sent < count; j++) begin
          if ($urandom_range(0, 4) == 0) tu = ~tu;
          offer(CSTATE_READY, 1'($urandom_range(0, 1)), tu, 1'b1);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len && sent < count; j++) begin
          offer(CSTATE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // receiver: short stalls, and one long hold when asked
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_word({relay_delta_on, relay_star_on, relay_down_on, relay_up_on},
                    {motor_delta_cmd, motor_star_cmd}, clear_starting_check);
    end
  end

  // watchdog on cycles with no progress
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_delay('0);

    // directed: other states, ready with and without check, start in delta
    offer(CSTATE_OTHER, 1'b0, 1'b0, 1'b0);
    offer(CSTATE_SPARE, 1'b1, 1'b1, 1'b1);
    offer(CSTATE_READY, 1'b1, 1'b1, 1'b0);
    offer(CSTATE_READY, 1'b0, 1'b1, 1'b1);
    offer(CSTATE_READY, 1'b1, 1'b0, 1'b1);
    repeat (16) offer(CSTATE_RUN, 1'b1, 1'b0, 1'b1);
    offer(CSTATE_READY, 1'b1, 1'b1, 1'b1);
    repeat (2) offer(CSTATE_RUN, 1'b0, 1'b1, 1'b0);
    offer(CSTATE_OTHER, 1'b1, 1'b1, 1'b1);
    drain_results();

    // random phases over several star times
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_delay(DELAY_W'(star_delays[p]));
      quiet       = (p == NUM_PHASES - 1);
      tx_idle_pct = (p == 1) ? 0 : $urandom_range(5, 40);
      rx_idle_pct = (p == 1) ? 0 : $urandom_range(5, 40);
      if (p == 0) begin
        // receiver holds off long enough for the input to back up
        run_phase(phase_lengths[p] / 2, star_delays[p]);
        hold_req = 1'b1;
        run_phase(phase_lengths[p] / 2, star_delays[p]);
      end else if (p == 1) begin
        // sender pauses until the block has emptied
        run_phase(phase_lengths[p] / 2, star_delays[p]);
        drain_results();
        run_phase(phase_lengths[p] / 2, star_delays[p]);
      end else begin
        run_phase(phase_lengths[p], star_delays[p]);
      end
      drain_results();
    end

    sb.errors += sb.expected_words.size();
    $display("ran %0d ticks (%0d words checked) over star times 0, 1, 2, 60 and 63 s",
             ticks_sent, sb.checked);
    $display("star drive in %0d words, delta drive in %0d, open gap in %0d, check cleared %0d",
             sb.star_words, sb.delta_words, sb.gap_words, sb.clear_words);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
